@@ rtl/core/direction_vector_scaled_to_speed_assert.svh @@
// assertion macros for the direction vector block
`ifndef DIRECTION_VECTOR_SCALED_TO_SPEED_ASSERT_SVH
`define DIRECTION_VECTOR_SCALED_TO_SPEED_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DVS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dvs_pkg.sv @@
package dvs_pkg;

    localparam int COORD_W     = 32;
    localparam int MAG_W       = 32;
    localparam int NORM_W      = 31;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int PROD_W      = 63;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic signed [COORD_W-1:0] speed;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      zero_length;
        logic                      saturated;
    } t_out;

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] c;
        c = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                c = 6'(31 - i);
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/direction_vector_scaled_to_speed.sv @@
// Pipeline from an accepted start to o_done: 5 front stages, 32 square-root stages,
// one product stage, 32 divider stages, one output stage.
// Throughput: one beat per cycle; o_busy is always low since the receiver cannot stall.
// Depth is set by the bit-per-stage square root and the bit-per-stage dividers.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data registers keep
// their contents and no result is strobed until new beats arrive.
`include "direction_vector_scaled_to_speed_assert.svh"

module direction_vector_scaled_to_speed (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  dvs_pkg::t_in  i_item,
    output logic          o_done,
    output dvs_pkg::t_out o_result
);

    localparam int NS = dvs_pkg::SQRT_STAGES;
    localparam int ND = dvs_pkg::DIV_STAGES;

    typedef struct packed {
        logic [dvs_pkg::NORM_W-1:0] n_x;
        logic [dvs_pkg::NORM_W-1:0] n_y;
        logic [dvs_pkg::NORM_W-1:0] n_z;
        logic [dvs_pkg::MAG_W-1:0]  spd;
        logic                       spd_neg;
        logic [2:0]                 d_neg;
        logic                       zero;
    } t_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_tail;

    logic w_acc;
    assign o_busy = 1'b0;
    assign w_acc  = i_start && !o_busy;

    // stage 1: differences and magnitudes
    logic [32:0] w_d [0:2];
    logic [dvs_pkg::MAG_W-1:0] r1_m [0:2];
    logic [2:0]                r1_neg;
    logic [dvs_pkg::MAG_W-1:0] r1_spd;
    logic                      r1_spd_neg;
    logic                      r1_v;

    assign w_d[0] = 33'(signed'(i_item.end_x)) - 33'(signed'(i_item.start_x));
    assign w_d[1] = 33'(signed'(i_item.end_y)) - 33'(signed'(i_item.start_y));
    assign w_d[2] = 33'(signed'(i_item.end_z)) - 33'(signed'(i_item.start_z));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_m[i]   <= w_d[i][32] ? 32'(-w_d[i]) : w_d[i][31:0];
            r1_neg[i] <= w_d[i][32];
        end
        r1_spd     <= i_item.speed[31] ? 32'(-i_item.speed) : i_item.speed;
        r1_spd_neg <= i_item.speed[31];
    end

    // stage 2: largest magnitude
    logic [dvs_pkg::MAG_W-1:0] w_mx01;
    logic [dvs_pkg::MAG_W-1:0] r2_m [0:2];
    logic [dvs_pkg::MAG_W-1:0] r2_mx;
    logic [2:0]                r2_neg;
    logic [dvs_pkg::MAG_W-1:0] r2_spd;
    logic                      r2_spd_neg;
    logic                      r2_v;

    assign w_mx01 = (r1_m[0] > r1_m[1]) ? r1_m[0] : r1_m[1];

    always_ff @(posedge i_clk) begin
        r2_m       <= r1_m;
        r2_mx      <= (w_mx01 > r1_m[2]) ? w_mx01 : r1_m[2];
        r2_neg     <= r1_neg;
        r2_spd     <= r1_spd;
        r2_spd_neg <= r1_spd_neg;
    end

    // stage 3: normalise so the largest lands in [2^30, 2^31)
    logic [5:0]                 w_lz;
    logic [4:0]                 w_k;
    logic [31:0]                w_sh [0:2];
    logic [dvs_pkg::NORM_W-1:0] w_n  [0:2];
    logic [dvs_pkg::NORM_W-1:0] r3_n [0:2];
    t_side                      r3_side;
    logic                       r3_v;

    assign w_lz = dvs_pkg::lzc32(r2_mx);
    assign w_k  = 5'(w_lz - 6'd1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i] = r2_m[i] << w_k;
            w_n[i]  = r2_mx[31] ? r2_m[i][31:1] : w_sh[i][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_n[i] <= w_n[i];
        end
        r3_side.spd     <= r2_spd;
        r3_side.spd_neg <= r2_spd_neg;
        r3_side.d_neg   <= r2_neg;
        r3_side.zero    <= (r2_mx == '0);
        r3_side.n_x     <= w_n[0];
        r3_side.n_y     <= w_n[1];
        r3_side.n_z     <= w_n[2];
    end

    // stage 4: squares
    logic [61:0] r4_sq [0:2];
    t_side       r4_side;
    logic        r4_v;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= 62'(r3_n[i]) * 62'(r3_n[i]);
        end
        r4_side <= r3_side;
    end

    // stage 5: sum of squares
    logic [dvs_pkg::SUM_W-1:0] r5_sum;
    t_side                     r5_side;
    logic                      r5_v;

    always_ff @(posedge i_clk) begin
        r5_sum  <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
        r5_side <= r4_side;
    end

    // square root with side payload alongside
    logic [dvs_pkg::ROOT_W-1:0] w_root;
    t_side                      r_sl  [0:NS-1];
    logic                       r_slv [0:NS-1];

    dvs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_sum  (r5_sum),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        r_sl[0] <= r5_side;
        for (int i = 1; i < NS; i++) begin
            r_sl[i] <= r_sl[i-1];
        end
    end

    // product stage
    logic [dvs_pkg::PROD_W-1:0] r6_p [0:2];
    logic [dvs_pkg::ROOT_W-1:0] r6_len;
    t_tail                      r6_tail;
    logic                       r6_v;

    always_ff @(posedge i_clk) begin
        r6_p[0]      <= 63'(r_sl[NS-1].n_x) * 63'(r_sl[NS-1].spd);
        r6_p[1]      <= 63'(r_sl[NS-1].n_y) * 63'(r_sl[NS-1].spd);
        r6_p[2]      <= 63'(r_sl[NS-1].n_z) * 63'(r_sl[NS-1].spd);
        r6_len       <= w_root;
        r6_tail.neg  <= r_sl[NS-1].d_neg ^ {3{r_sl[NS-1].spd_neg}};
        r6_tail.zero <= r_sl[NS-1].zero;
    end

    // dividers
    logic [31:0] w_q [0:2];
    t_tail       r_tl  [0:ND-1];
    logic        r_tlv [0:ND-1];

    for (genvar c = 0; c < 3; c++) begin : g_div
        dvs_div u_div (
            .i_clk (i_clk),
            .i_num (r6_p[c]),
            .i_den (r6_len),
            .o_quo (w_q[c])
        );
    end

    always_ff @(posedge i_clk) begin
        r_tl[0] <= r6_tail;
        for (int i = 1; i < ND; i++) begin
            r_tl[i] <= r_tl[i-1];
        end
    end

    // output stage: sign, clamp, zero length
    logic [31:0] w_o   [0:2];
    logic [2:0]  w_sat;
    dvs_pkg::t_out r_res;
    logic          r_done;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sat[i] = 1'b0;
            if (r_tl[ND-1].neg[i]) begin
                w_o[i] = 32'(-w_q[i]);
            end else if (w_q[i][31]) begin
                w_o[i]   = 32'h7FFF_FFFF;
                w_sat[i] = 1'b1;
            end else begin
                w_o[i] = w_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tl[ND-1].zero) begin
            r_res.out_x       <= '0;
            r_res.out_y       <= '0;
            r_res.out_z       <= '0;
            r_res.zero_length <= 1'b1;
            r_res.saturated   <= 1'b0;
        end else begin
            r_res.out_x       <= w_o[0];
            r_res.out_y       <= w_o[1];
            r_res.out_z       <= w_o[2];
            r_res.zero_length <= 1'b0;
            r_res.saturated   <= |w_sat;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r6_v   <= 1'b0;
            r_done <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                r_slv[i] <= 1'b0;
            end
            for (int i = 0; i < ND; i++) begin
                r_tlv[i] <= 1'b0;
            end
        end else begin
            r1_v     <= w_acc;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r5_v     <= r4_v;
            r_slv[0] <= r5_v;
            for (int i = 1; i < NS; i++) begin
                r_slv[i] <= r_slv[i-1];
            end
            r6_v     <= r_slv[NS-1];
            r_tlv[0] <= r6_v;
            for (int i = 1; i < ND; i++) begin
                r_tlv[i] <= r_tlv[i-1];
            end
            r_done   <= r_tlv[ND-1];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `DVS_ASSERT_IMPL(a_zero_out, o_done && o_result.zero_length, o_result.out_x == '0 && o_result.out_y == '0 && o_result.out_z == '0 && !o_result.saturated, "zero-length beat with non-zero result")
    `DVS_ASSERT_IMPL(a_sat_clamp, o_done && o_result.saturated, o_result.out_x == 32'h7FFF_FFFF || o_result.out_y == 32'h7FFF_FFFF || o_result.out_z == 32'h7FFF_FFFF, "saturation flagged without a clamped component")
    `DVS_ASSERT_IMPL(a_root_norm, r_slv[NS-1] && !r_sl[NS-1].zero, w_root[31] || w_root[30], "length below normalised range")
    `DVS_ASSERT_NEXT(a_done_follow, r_tlv[ND-1], o_done, "result beat lost at output stage")

endmodule

@@ rtl/core/dvs_sqrt.sv @@
module dvs_sqrt (
    input  logic                              i_clk,
    input  logic [dvs_pkg::SUM_W-1:0]         i_sum,
    output logic [dvs_pkg::ROOT_W-1:0]        o_root
);

    localparam int N = dvs_pkg::SQRT_STAGES;

    logic [33:0]                      r_rem  [0:N-1];
    logic [dvs_pkg::ROOT_W-1:0]       r_root [0:N-1];
    logic [dvs_pkg::SUM_W-1:0]        r_sum  [0:N-1];

    for (genvar g = 0; g < N; g++) begin : g_st
        logic [33:0]                rem_in;
        logic [dvs_pkg::ROOT_W-1:0] root_in;
        logic [dvs_pkg::SUM_W-1:0]  sum_in;
        logic [35:0]                acc;
        logic [35:0]                trial;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign sum_in  = i_sum;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign sum_in  = r_sum[g-1];
        end

        assign acc   = {rem_in, sum_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (acc >= trial) begin
                r_rem[g]  <= 34'(acc - trial);
                r_root[g] <= {root_in[30:0], 1'b1};
            end else begin
                r_rem[g]  <= acc[33:0];
                r_root[g] <= {root_in[30:0], 1'b0};
            end
            r_sum[g] <= {sum_in[61:0], 2'b00};
        end
    end

    assign o_root = r_root[N-1];

endmodule

@@ rtl/core/dvs_div.sv @@
module dvs_div (
    input  logic                         i_clk,
    input  logic [dvs_pkg::PROD_W-1:0]   i_num,
    input  logic [dvs_pkg::ROOT_W-1:0]   i_den,
    output logic [31:0]                  o_quo
);

    localparam int N = dvs_pkg::DIV_STAGES;

    logic [31:0]                r_rem [0:N-1];
    logic [31:0]                r_lo  [0:N-1];
    logic [31:0]                r_quo [0:N-1];
    logic [dvs_pkg::ROOT_W-1:0] r_den [0:N-1];

    for (genvar g = 0; g < N; g++) begin : g_st
        logic [31:0]                rem_in;
        logic [31:0]                lo_in;
        logic [31:0]                quo_in;
        logic [dvs_pkg::ROOT_W-1:0] den_in;
        logic [32:0]                acc;

        if (g == 0) begin : g_first
            assign rem_in = {1'b0, i_num[62:32]};
            assign lo_in  = i_num[31:0];
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign lo_in  = r_lo[g-1];
            assign quo_in = r_quo[g-1];
            assign den_in = r_den[g-1];
        end

        assign acc = {rem_in, lo_in[31]};

        always_ff @(posedge i_clk) begin
            if (acc >= {1'b0, den_in}) begin
                r_rem[g] <= 32'(acc - {1'b0, den_in});
                r_quo[g] <= {quo_in[30:0], 1'b1};
            end else begin
                r_rem[g] <= acc[31:0];
                r_quo[g] <= {quo_in[30:0], 1'b0};
            end
            r_lo[g]  <= {lo_in[30:0], 1'b0};
            r_den[g] <= den_in;
        end
    end

    assign o_quo = r_quo[N-1];

endmodule

@@ dv/dvs_checker.sv @@
`timescale 1ns / 1ps

module dvs_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  dvs_pkg::t_in  i_item,
    input  logic          i_done,
    input  dvs_pkg::t_out i_result,
    output int            o_fail_count,
    output int            o_pending
);

    dvs_pkg::t_out exp_q[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] rem, root, b;
        rem  = s;
        root = 0;
        b    = 64'h1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic dvs_pkg::t_out scale_direction(input dvs_pkg::t_in it);
        dvs_pkg::t_out r;
        logic signed [63:0] d[3];
        logic [63:0] m[3], n[3], mx, s, len, smag, q;
        logic signed [63:0] spd;
        logic neg;
        int k;
        d[0] = 64'(it.end_x) - 64'(it.start_x);
        d[1] = 64'(it.end_y) - 64'(it.start_y);
        d[2] = 64'(it.end_z) - 64'(it.start_z);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            if (m[i] > mx) mx = m[i];
        end
        r = '0;
        if (mx == 0) begin
            r.zero_length = 1'b1;
            return r;
        end
        if (mx >= 64'h8000_0000) begin
            for (int i = 0; i < 3; i++) n[i] = m[i] >> 1;
        end else begin
            k = 0;
            while ((mx << k) < 64'h4000_0000) k++;
            for (int i = 0; i < 3; i++) n[i] = m[i] << k;
        end
        s = 0;
        for (int i = 0; i < 3; i++) s = s + n[i] * n[i];
        len  = int_sqrt(s);
        spd  = 64'(it.speed);
        smag = spd < 0 ? 64'(-spd) : 64'(spd);
        for (int i = 0; i < 3; i++) begin
            q   = (len != 0) ? (n[i] * smag) / len : 0;
            neg = (d[i] < 0) != (spd < 0);
            if (neg) begin
                q = -q;
            end else if (q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
                r.saturated = 1'b1;
            end
            case (i)
                0: r.out_x = q[31:0];
                1: r.out_y = q[31:0];
                default: r.out_z = q[31:0];
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        dvs_pkg::t_out e;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else if (i_done) begin
            if (exp_q.size() == 0) begin
                $error("result beat with nothing expected");
                o_fail_count <= o_fail_count + 1;
            end else begin
                e = exp_q.pop_front();
                if (i_result !== e) begin
                    o_fail_count <= o_fail_count + 1;
                    if (i_result.out_x !== e.out_x)
                        $error("out_x exp %0d got %0d", e.out_x, i_result.out_x);
                    if (i_result.out_y !== e.out_y)
                        $error("out_y exp %0d got %0d", e.out_y, i_result.out_y);
                    if (i_result.out_z !== e.out_z)
                        $error("out_z exp %0d got %0d", e.out_z, i_result.out_z);
                    if (i_result.zero_length !== e.zero_length)
                        $error("zero_length exp %0b got %0b", e.zero_length,
                               i_result.zero_length);
                    if (i_result.saturated !== e.saturated)
                        $error("saturated exp %0b got %0b", e.saturated,
                               i_result.saturated);
                end
            end
        end
        if (i_rst_n && i_start && !i_busy) exp_q.push_back(scale_direction(i_item));
        o_pending <= exp_q.size();
    end
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_start = 1'b0;
    logic  o_busy, o_done;
    dvs_pkg::t_in  i_item = '0;
    dvs_pkg::t_out o_result;
    int    fail_count, pending;

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    always #5 i_clk = ~i_clk;

    direction_vector_scaled_to_speed dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result)
    );

    dvs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_item(i_item), .i_done(o_done), .i_result(o_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return MAXV;
            1: return MINV;
            2: return 32'($urandom_range(0, 16)) - 8;
            3: return 32'($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom();
        endcase
    endfunction

    // one beat, then an optional random gap
    task automatic send_beat(input dvs_pkg::t_in it, input bit gaps);
        int gap;
        i_item  <= it;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        gap = gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_point(input logic [31:0] sx, sy, sz, ex, ey, ez, sp);
        dvs_pkg::t_in it;
        it = '{sx, sy, sz, ex, ey, ez, sp};
        send_beat(it, 1'b1);
    endtask

    initial begin
        dvs_pkg::t_in it;
        bit  gaps;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_point(0, 0, 0, 0, 0, 0, 32'h0001_0000);
        send_point(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MINV);
        send_point(MINV, 0, 0, MAXV, 0, 0, MAXV);
        send_point(MAXV, 0, 0, MINV, 0, 0, MINV);
        send_point(0, MAXV, 0, 0, MINV, 0, MINV);
        send_point(0, 0, MAXV, 0, 0, MINV, MAXV);
        send_point(0, 0, 0, 0, 0, 32'hFFFF_FFFF, MINV);
        send_point(0, 0, 0, 1, 0, 0, MINV);
        send_point(0, 0, 0, 1, 1, 1, MAXV);
        send_point(0, 0, 0, 3, 4, 0, 32'h0001_0000);
        send_point(5, 5, 5, 1, 2, 3, 0);
        send_point(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV);
        send_point(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV);
        send_point(0, 0, 0, MINV, MINV, MINV, 32'hFFFF_FFFF);
        send_point(0, 0, 0, 32'h0001_0000, 0, 0, 1);
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < 1450; n++) begin
            for (int f = 0; f < 7; f++) it[f*32 +: 32] = rand_coord();
            if ($urandom_range(0, 9) == 0) begin
                it.end_x = it.start_x;
                it.end_y = it.start_y;
                it.end_z = it.start_z;
            end
            if ($urandom_range(0, 19) == 0) it.speed = MINV;
            if (n % 200 == 0) gaps = ~gaps;
            send_beat(it, gaps && $urandom_range(0, 1));
        end
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
